// File: rtl/wgdh_pkg.sv
// Shared widths, defaults and operation codes for the wind statistics block.
`timescale 1ns / 1ps
package wgdh_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 12;
  localparam int unsigned SECTOR_COUNT_DEF = 32;

  localparam int unsigned OP_W  = 3;
  localparam int unsigned TS_W  = 32;
  localparam int unsigned RAW_W = 12;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned SUM_W = 22;
  localparam int unsigned DEB_W = 8;

  localparam int unsigned SECTOR_SHIFT = 7;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd5;

  typedef enum logic [OP_W-1:0] {
    OP_PULSE = 3'd0,
    OP_GUST  = 3'd1,
    OP_DIR   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_e;

endpackage

// File: rtl/wgdh_in_if.sv
// Input channel: one operation item with its payload fields.
`timescale 1ns / 1ps
interface wgdh_in_if;
  import wgdh_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [TS_W-1:0]  timestamp_ms;
  logic [RAW_W-1:0] direction_raw;
  logic             force_flush;
  logic [IDX_W-1:0] bin_index;

  modport source (
    output valid, op, timestamp_ms, direction_raw, force_flush, bin_index,
    input  ready
  );

  modport sink (
    input  valid, op, timestamp_ms, direction_raw, force_flush, bin_index,
    output ready
  );

endinterface

// File: rtl/wgdh_out_if.sv
// Output channel: one result item with the statistics after an operation.
`timescale 1ns / 1ps
interface wgdh_out_if;
  import wgdh_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] revolution_count;
  logic [CNT_W-1:0] max_gust;
  logic [CNT_W-1:0] bin_value;
  logic [SUM_W-1:0] histogram_total;
  logic             pulse_accepted;

  modport source (
    output valid, revolution_count, max_gust, bin_value, histogram_total, pulse_accepted,
    input  ready
  );

  modport sink (
    input  valid, revolution_count, max_gust, bin_value, histogram_total, pulse_accepted,
    output ready
  );

endinterface

// File: rtl/wind_gust_and_direction_histogram.sv
// Top level of the anemometer statistics block: sequencer, shared adder and stores.
`timescale 1ns / 1ps
// Takes one item at a time: pulse, gust poll, direction sample, clear or read, and
// returns one result item per input item. An accepted item passes through a fetch of
// the ring slot and the bin, one to four passes through the single shared 32-bit
// adder/subtractor (pulse 2 or 3, gust poll 2, direction sample 1 or 4, others 1),
// a read of the requested bin from the bin memory and a load of the output
// register, and then returns to idle, where the next item is taken. The result
// register holds a finished item until the sink takes it; the block stalls before
// loading a second result if the first is still waiting. The bin and ring memories
// have per-entry valid bits, so reset empties both and a clear empties the bin
// memory at once, with no clearing pass.
module wind_gust_and_direction_histogram #(
  parameter int unsigned WINDOW_DEPTH = wgdh_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SECTOR_COUNT = wgdh_pkg::SECTOR_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wgdh_pkg::DEB_W-1:0] cfg_wdata_i,
  wgdh_in_if.sink                    in_i,
  wgdh_out_if.source                 out_o
);
  import wgdh_pkg::*;

  localparam int unsigned POS_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned SEC_W  = $clog2(SECTOR_COUNT);
  localparam int unsigned RSEC_W = RAW_W - SECTOR_SHIFT;
  localparam int unsigned ALU_W  = TS_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_STEP  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] step_q, step_d;

  // Architectural state.
  logic [DEB_W-1:0] deb_q;
  logic [CNT_W-1:0] rev_q, rev_d;
  logic [TS_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [CNT_W-1:0] flush_q, flush_d;
  logic [SEC_W-1:0] prev_q, prev_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [POS_W-1:0] pos_q, pos_d;

  // Latched item and working registers.
  logic [OP_W-1:0]  op_q;
  logic [TS_W-1:0]  ts_q;
  logic [SEC_W-1:0] sector_q;
  logic             force_q;
  logic [IDX_W-1:0] idx_q;
  logic             idx_ok_q;
  logic [ALU_W-1:0] tmp_q, tmp_d;
  logic [CNT_W-1:0] nb_q, nb_d;
  logic             hit_q, hit_d;

  // Memories with per-entry valid bits.
  logic [CNT_W-1:0]        bin_mem [SECTOR_COUNT];
  logic [SECTOR_COUNT-1:0] bin_vld_q;
  logic [CNT_W-1:0]        bin_rd_q;
  logic                    bin_rd_vld_q;
  logic [CNT_W-1:0]        ring_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ring_vld_q;
  logic [CNT_W-1:0]        ring_rd_q;
  logic                    ring_rd_vld_q;

  logic             bin_we, bin_re, bin_clr, ring_we, ring_re;
  logic [SEC_W-1:0] bin_raddr;
  logic [CNT_W-1:0] bin_old, ring_old;

  // Shared adder/subtractor.
  logic [ALU_W-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [ALU_W:0]   alu_res;

  // Output register.
  logic             out_valid_q, out_load;
  logic [CNT_W-1:0] out_rev_q, out_peak_q, out_bin_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_hit_q;

  logic             in_acc;
  logic [RSEC_W-1:0] raw_sector;
  logic [SEC_W-1:0] in_sector;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign raw_sector = in_i.direction_raw[RAW_W-1:SECTOR_SHIFT];
  assign in_sector  = (32'(raw_sector) >= SECTOR_COUNT) ? SEC_W'(SECTOR_COUNT - 1)
                                                        : SEC_W'(raw_sector);

  assign bin_old  = bin_rd_vld_q ? bin_rd_q : '0;
  assign ring_old = ring_rd_vld_q ? ring_rd_q : '0;

  // A set top bit after a subtraction means no borrow, that is a >= b.
  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ALU_W + 1)'(alu_sub);

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    rev_d     = rev_q;
    last_d    = last_q;
    peak_d    = peak_q;
    flush_d   = flush_q;
    prev_d    = prev_q;
    sum_d     = sum_q;
    pos_d     = pos_q;
    tmp_d     = tmp_q;
    nb_d      = nb_q;
    hit_d     = hit_q;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    bin_we    = 1'b0;
    bin_re    = 1'b0;
    bin_clr   = 1'b0;
    bin_raddr = prev_q;
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        bin_re  = 1'b1;
        ring_re = 1'b1;
        step_d  = '0;
        hit_d   = 1'b0;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        case (op_q)
          OP_PULSE: begin
            case (step_q)
              2'd0: begin
                alu_a   = ts_q;
                alu_b   = last_q;
                alu_sub = 1'b1;
                tmp_d   = alu_res[ALU_W-1:0];
                step_d  = 2'd1;
              end
              2'd1: begin
                // Borrow from debounce minus elapsed time means the gap is long enough.
                alu_a   = ALU_W'(deb_q);
                alu_b   = tmp_q;
                alu_sub = 1'b1;
                if (!alu_res[ALU_W]) begin
                  hit_d  = 1'b1;
                  step_d = 2'd2;
                end else begin
                  state_d = ST_READ;
                end
              end
              default: begin
                alu_a   = ALU_W'(rev_q);
                alu_b   = ALU_W'(1);
                rev_d   = alu_res[CNT_W] ? '1 : alu_res[CNT_W-1:0];
                last_d  = ts_q;
                state_d = ST_READ;
              end
            endcase
          end
          OP_GUST: begin
            case (step_q)
              2'd0: begin
                alu_a   = ALU_W'(rev_q);
                alu_b   = ALU_W'(ring_old);
                alu_sub = 1'b1;
                tmp_d   = alu_res[ALU_W] ? ALU_W'(alu_res[CNT_W-1:0]) : '0;
                step_d  = 2'd1;
              end
              default: begin
                alu_a   = ALU_W'(peak_q);
                alu_b   = tmp_q;
                alu_sub = 1'b1;
                if (!alu_res[ALU_W]) begin
                  peak_d = tmp_q[CNT_W-1:0];
                end
                ring_we = 1'b1;
                pos_d   = (pos_q == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_q + POS_W'(1);
                state_d = ST_READ;
              end
            endcase
          end
          OP_DIR: begin
            case (step_q)
              2'd0: begin
                if ((sector_q != prev_q) || force_q) begin
                  alu_a   = ALU_W'(rev_q);
                  alu_b   = ALU_W'(flush_q);
                  alu_sub = 1'b1;
                  tmp_d   = alu_res[ALU_W] ? ALU_W'(alu_res[CNT_W-1:0]) : '0;
                  step_d  = 2'd1;
                end else begin
                  state_d = ST_READ;
                end
              end
              2'd1: begin
                alu_a  = ALU_W'(bin_old);
                alu_b  = tmp_q;
                nb_d   = alu_res[CNT_W] ? '1 : alu_res[CNT_W-1:0];
                step_d = 2'd2;
              end
              2'd2: begin
                // The total grows only by what the bin really gained.
                alu_a   = ALU_W'(nb_q);
                alu_b   = ALU_W'(bin_old);
                alu_sub = 1'b1;
                tmp_d   = ALU_W'(alu_res[CNT_W-1:0]);
                step_d  = 2'd3;
              end
              default: begin
                alu_a   = ALU_W'(sum_q);
                alu_b   = tmp_q;
                sum_d   = alu_res[SUM_W] ? '1 : alu_res[SUM_W-1:0];
                bin_we  = 1'b1;
                flush_d = rev_q;
                prev_d  = sector_q;
                state_d = ST_READ;
              end
            endcase
          end
          OP_CLEAR: begin
            rev_d   = '0;
            sum_d   = '0;
            flush_d = '0;
            peak_d  = '0;
            bin_clr = 1'b1;
            state_d = ST_READ;
          end
          default: begin
            state_d = ST_READ;
          end
        endcase
      end
      ST_READ: begin
        bin_re    = 1'b1;
        bin_raddr = SEC_W'(idx_q);
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      deb_q       <= DEBOUNCE_RESET;
      rev_q       <= '0;
      last_q      <= '0;
      peak_q      <= '0;
      flush_q     <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      pos_q       <= '0;
      bin_vld_q   <= '0;
      ring_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        deb_q <= cfg_wdata_i;
      end
      rev_q   <= rev_d;
      last_q  <= last_d;
      peak_q  <= peak_d;
      flush_q <= flush_d;
      prev_q  <= prev_d;
      sum_q   <= sum_d;
      pos_q   <= pos_d;
      if (bin_clr) begin
        bin_vld_q <= '0;
      end else if (bin_we) begin
        bin_vld_q[prev_q] <= 1'b1;
      end
      if (ring_we) begin
        ring_vld_q[pos_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_i.op;
      ts_q     <= in_i.timestamp_ms;
      sector_q <= in_sector;
      force_q  <= in_i.force_flush;
      idx_q    <= in_i.bin_index;
      idx_ok_q <= (32'(in_i.bin_index) < SECTOR_COUNT);
    end
    tmp_q <= tmp_d;
    nb_q  <= nb_d;
    hit_q <= hit_d;
    if (out_load) begin
      out_rev_q  <= rev_q;
      out_peak_q <= peak_q;
      out_bin_q  <= idx_ok_q ? bin_old : '0;
      out_sum_q  <= sum_q;
      out_hit_q  <= hit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[prev_q] <= nb_q;
    end
    if (bin_re) begin
      bin_rd_q     <= bin_mem[bin_raddr];
      bin_rd_vld_q <= bin_vld_q[bin_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= rev_q;
    end
    if (ring_re) begin
      ring_rd_q     <= ring_mem[pos_q];
      ring_rd_vld_q <= ring_vld_q[pos_q];
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.revolution_count = out_rev_q;
  assign out_o.max_gust         = out_peak_q;
  assign out_o.bin_value        = out_bin_q;
  assign out_o.histogram_total  = out_sum_q;
  assign out_o.pulse_accepted   = out_hit_q;

endmodule

// File: rtl/wgdh_checker.sv
// Port-level assertions for the wind statistics block, bound to its top level.
`timescale 1ns / 1ps
module wgdh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [wgdh_pkg::CNT_W-1:0] revolution_count_i,
  input logic [wgdh_pkg::CNT_W-1:0] max_gust_i,
  input logic [wgdh_pkg::CNT_W-1:0] bin_value_i,
  input logic [wgdh_pkg::SUM_W-1:0] histogram_total_i,
  input logic                       pulse_accepted_i
);
  import wgdh_pkg::*;

  // A waiting result item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item withdrawn while stalled");

  // A waiting result item keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(revolution_count_i) && $stable(max_gust_i)
      && $stable(bin_value_i) && $stable(histogram_total_i) && $stable(pulse_accepted_i))
    else $error("result payload changed while stalled");

  // An accepted item keeps the block busy through fetch, step, read and load.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("input taken while an item is still in progress");

  // A counted pulse always leaves a nonzero revolution count.
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pulse_accepted_i |-> revolution_count_i != '0)
    else $error("counted pulse reported with zero revolutions");

endmodule

bind wind_gust_and_direction_histogram wgdh_checker u_wgdh_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .revolution_count_i (out_o.revolution_count),
  .max_gust_i         (out_o.max_gust),
  .bin_value_i        (out_o.bin_value),
  .histogram_total_i  (out_o.histogram_total),
  .pulse_accepted_i   (out_o.pulse_accepted)
);

// File: test/wind_stats_checker.sv
// Checker that follows both channels of the wind statistics block and compares every result item.
`timescale 1ns / 1ps
module wind_stats_checker #(
  parameter int unsigned WINDOW_DEPTH = wgdh_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SECTOR_COUNT = wgdh_pkg::SECTOR_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wgdh_pkg::DEB_W-1:0] cfg_wdata_i,
  wgdh_in_if                         item_i,
  wgdh_out_if                        stat_i,
  output int unsigned                error_count_o,
  output int unsigned                pending_o
);
  import wgdh_pkg::*;

  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned SUM_MAX = (1 << SUM_W) - 1;

  typedef struct packed {
    logic [CNT_W-1:0] revolution_count;
    logic [CNT_W-1:0] max_gust;
    logic [CNT_W-1:0] bin_value;
    logic [SUM_W-1:0] histogram_total;
    logic             pulse_accepted;
  } wind_stats_t;

  logic [DEB_W-1:0] debounce_q;
  logic [CNT_W-1:0] revs;
  logic [TS_W-1:0]  last_pulse_ts;
  logic [CNT_W-1:0] ring_slots [WINDOW_DEPTH];
  int unsigned      ring_ptr;
  logic [CNT_W-1:0] peak;
  int unsigned      prev_sector;
  logic [CNT_W-1:0] flush_mark;
  logic [CNT_W-1:0] sector_bins [SECTOR_COUNT];
  logic [SUM_W-1:0] bins_total;

  wind_stats_t expected_stats_q[$];
  int unsigned mismatches = 0;

  assign error_count_o = mismatches;

  task automatic clear_totals();
    for (int i = 0; i < SECTOR_COUNT; i++) begin
      sector_bins[i] = '0;
    end
    bins_total = '0;
    revs       = '0;
    flush_mark = '0;
    peak       = '0;
  endtask

  task automatic reset_model();
    debounce_q = DEBOUNCE_RESET;
    clear_totals();
    last_pulse_ts = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      ring_slots[i] = '0;
    end
    ring_ptr    = 0;
    prev_sector = 0;
  endtask

  task automatic predict_wind_stats(
    input  logic [OP_W-1:0]  op,
    input  logic [TS_W-1:0]  ts,
    input  logic [RAW_W-1:0] raw,
    input  logic             flush_req,
    input  logic [IDX_W-1:0] idx,
    output wind_stats_t      stats
  );
    logic [TS_W-1:0]  since_last;
    logic [CNT_W-1:0] oldest;
    logic [CNT_W-1:0] rise;
    int unsigned      sector;
    int unsigned      gain;
    int unsigned      grown;
    int unsigned      total;
    logic             counted;
    counted = 1'b0;
    case (op)
      OP_PULSE: begin
        // Wrapping subtraction, so a timestamp that rolled over still counts.
        since_last = ts - last_pulse_ts;
        if (since_last > debounce_q) begin
          if (revs != CNT_MAX) begin
            revs = revs + 1'b1;
          end
          last_pulse_ts = ts;
          counted       = 1'b1;
        end
      end
      OP_GUST: begin
        oldest = ring_slots[ring_ptr];
        rise   = (revs > oldest) ? revs - oldest : '0;
        ring_slots[ring_ptr] = revs;
        if (rise > peak) begin
          peak = rise;
        end
        ring_ptr = (ring_ptr + 1 >= WINDOW_DEPTH) ? 0 : ring_ptr + 1;
      end
      OP_DIR: begin
        sector = 32'(raw[RAW_W-1:SECTOR_SHIFT]);
        if (sector >= SECTOR_COUNT) begin
          sector = SECTOR_COUNT - 1;
        end
        if (sector != prev_sector || flush_req) begin
          // The revolutions since the last flush belong to the sector just left.
          gain  = (revs > flush_mark) ? 32'(revs - flush_mark) : 0;
          grown = 32'(sector_bins[prev_sector]) + gain;
          if (grown > CNT_MAX) begin
            grown = CNT_MAX;
          end
          total = 32'(bins_total) + (grown - 32'(sector_bins[prev_sector]));
          if (total > SUM_MAX) begin
            total = SUM_MAX;
          end
          bins_total               = SUM_W'(total);
          sector_bins[prev_sector] = CNT_W'(grown);
          flush_mark               = revs;
          prev_sector              = sector;
        end
      end
      OP_CLEAR: begin
        clear_totals();
      end
      default: begin
      end
    endcase
    stats.revolution_count = revs;
    stats.max_gust         = peak;
    stats.bin_value        = (idx < SECTOR_COUNT) ? sector_bins[idx] : '0;
    stats.histogram_total  = bins_total;
    stats.pulse_accepted   = counted;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wind_stats_t want;
    wind_stats_t next_stats;
    if (!rst_ni) begin
      reset_model();
      expected_stats_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        debounce_q = cfg_wdata_i;
      end
      if (stat_i.valid && stat_i.ready) begin
        if (expected_stats_q.size() == 0) begin
          mismatches++;
          $display("%0t: result item with none expected, expected nothing, got count %0d",
                   $time, stat_i.revolution_count);
        end else begin
          want = expected_stats_q.pop_front();
          check_field("revolution_count", 32'(want.revolution_count),
                      32'(stat_i.revolution_count));
          check_field("max_gust", 32'(want.max_gust), 32'(stat_i.max_gust));
          check_field("bin_value", 32'(want.bin_value), 32'(stat_i.bin_value));
          check_field("histogram_total", 32'(want.histogram_total),
                      32'(stat_i.histogram_total));
          check_field("pulse_accepted", 32'(want.pulse_accepted), 32'(stat_i.pulse_accepted));
        end
      end
      if (item_i.valid && item_i.ready) begin
        predict_wind_stats(item_i.op, item_i.timestamp_ms, item_i.direction_raw,
                           item_i.force_flush, item_i.bin_index, next_stats);
        expected_stats_q.push_back(next_stats);
      end
      pending_o <= expected_stats_q.size();
    end
  end

endmodule

// File: test/testbench.sv
// Top of the wind statistics testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import wgdh_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS     = 85;
  localparam int unsigned BURST_PULSES    = 40;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_READ + 1'b1;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [DEB_W-1:0] cfg_wdata;

  wgdh_in_if  item_ch ();
  wgdh_out_if stat_ch ();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned waiting;
  int unsigned quiet_cycles;
  int unsigned debounce_now;
  logic [TS_W-1:0] clock_ms;
  logic [RAW_W-SECTOR_SHIFT-1:0] cur_sector;

  wind_gust_and_direction_histogram DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (item_ch),
    .out_o       (stat_ch)
  );

  wind_stats_checker u_stats_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .item_i        (item_ch),
    .stat_i        (stat_ch),
    .error_count_o (mismatches),
    .pending_o     (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    stat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (stat_ch.valid && stat_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Drives one item on the input channel and returns once the block has taken it.
  task automatic send_item(
    input logic [OP_W-1:0]  op,
    input logic [TS_W-1:0]  ts,
    input logic [RAW_W-1:0] raw,
    input logic             flush_bit,
    input logic [IDX_W-1:0] idx
  );
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.op            <= op;
    item_ch.timestamp_ms  <= ts;
    item_ch.direction_raw <= raw;
    item_ch.force_flush   <= flush_bit;
    item_ch.bin_index     <= idx;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [DEB_W-1:0] value);
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    debounce_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_item();
    logic [OP_W-1:0]  op;
    logic [TS_W-1:0]  ts;
    logic [RAW_W-1:0] raw;
    int unsigned      pick;
    pick = $urandom_range(99);
    ts   = $urandom();
    raw  = RAW_W'($urandom());
    if (pick < 50) begin
      op = OP_PULSE;
      // Steps straddle the debounce limit; now and then a jump anywhere, even backward.
      if ($urandom_range(19) == 0) begin
        ts = $urandom();
      end else begin
        ts = clock_ms + $urandom_range(2 * debounce_now + 2);
      end
      clock_ms = ts;
    end else if (pick < 65) begin
      op = OP_GUST;
    end else if (pick < 83) begin
      op = OP_DIR;
      if ($urandom_range(99) < 40) begin
        raw = {cur_sector, SECTOR_SHIFT'($urandom())};
      end
      cur_sector = raw[RAW_W-1:SECTOR_SHIFT];
    end else if (pick < 93) begin
      op = OP_READ;
    end else if (pick < 96) begin
      op = OP_CLEAR;
    end else begin
      op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    end
    send_item(op, ts, raw, ($urandom_range(99) < 30), IDX_W'($urandom()));
  endtask

  initial begin
    logic [DEB_W-1:0] phase_debounce [RANDOM_PHASES];
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    item_ch.valid         = 1'b0;
    item_ch.op            = OP_READ;
    item_ch.timestamp_ms  = '0;
    item_ch.direction_raw = '0;
    item_ch.force_flush   = 1'b0;
    item_ch.bin_index     = '0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    debounce_now          = DEBOUNCE_RESET;
    clock_ms              = '0;
    cur_sector            = '0;
    phase_debounce = '{8'd255, 8'd0, 8'd1, DEB_W'($urandom()), 8'd128,
                       DEB_W'($urandom()), DEBOUNCE_RESET, DEB_W'($urandom())};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the debounce still at its reset value.
    send_item(OP_READ, '1, '1, 1'b1, '1);
    send_item(OP_PULSE, 32'd0, '0, 1'b0, '0);
    send_item(OP_PULSE, 32'd5, '0, 1'b0, '0);
    send_item(OP_PULSE, 32'd6, '0, 1'b0, '0);
    send_item(OP_PULSE, '1, '0, 1'b0, '0);
    send_item(OP_PULSE, 32'd4, '0, 1'b0, '0);
    send_item(OP_PULSE, 32'd5, '0, 1'b0, '0);
    for (int i = 0; i < WINDOW_DEPTH_DEF; i++) begin
      send_item(OP_GUST, '0, '0, 1'b0, IDX_W'(i));
    end
    send_item(OP_DIR, '0, 12'hFFF, 1'b0, '0);
    send_item(OP_DIR, '0, 12'hF80, 1'b1, '1);
    send_item(OP_DIR, '0, 12'h000, 1'b0, '1);
    send_item(OP_SPARE_FIRST, '0, '0, 1'b0, '0);
    send_item(OP_SPARE_LAST, '1, '1, 1'b1, '0);
    send_item(OP_READ, '0, '0, 1'b0, '0);
    send_item(OP_CLEAR, '0, '0, 1'b0, '0);
    // The ring still holds counts from before the clear, so this increase would be negative and is clamped to zero.
    send_item(OP_GUST, '0, '0, 1'b0, '0);
    clock_ms   = 32'd5;
    cur_sector = '0;

    // A burst of pulses one millisecond apart with no debounce, so every one counts.
    drain();
    set_debounce(8'd0);
    for (int i = 0; i < BURST_PULSES; i++) begin
      clock_ms = clock_ms + 1'b1;
      send_item(OP_PULSE, clock_ms, RAW_W'($urandom()), 1'($urandom()), IDX_W'($urandom()));
    end
    send_item(OP_GUST, '0, '0, 1'b0, '0);
    send_item(OP_DIR, '0, 12'h800, 1'b1, '0);
    send_item(OP_READ, '0, '0, 1'b0, '0);
    cur_sector = (RAW_W - SECTOR_SHIFT)'(12'h800 >> SECTOR_SHIFT);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      set_debounce(phase_debounce[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // One phase starts its timestamps just below the 32-bit wrap.
      if (p == 2) begin
        clock_ms = 32'hFFFF_FE00;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random_item();
      end
    end

    drain();
    if (mismatches == 0 && waiting == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
